// File: rtl/msp_pkg.sv
// Package for the motor speed controller: state and register-index codes,
// field widths and register reset values. No dependencies.
`default_nettype none

package msp_pkg;

   localparam int TARGET_W   = 15;
   localparam int GEAR_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int LIMIT_W    = 18;
   localparam int DUTY_W     = 10;
   localparam int STALL_W    = 8;
   localparam int RPM_W      = 26;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam int TGT_W      = 24;
   localparam int INTEG_W    = 20;
   localparam int MEAS_GAIN  = 12000;
   localparam int MIN_MAG    = 26;

   localparam logic [GEAR_W-1:0]  GEAR_RESET     = 16'd33536;
   localparam logic [GAIN_W-1:0]  KP_RESET       = 16'd6554;
   localparam logic [GAIN_W-1:0]  KI_RESET       = 16'd655;
   localparam logic [GAIN_W-1:0]  KD_RESET       = 16'd0;
   localparam logic [GAIN_W-1:0]  FF_RESET       = 16'd14898;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 18'd130944;
   localparam logic [DUTY_W-1:0]  MIN_DUTY_RESET = 10'd150;
   localparam logic [STALL_W-1:0] STALL_RESET    = 8'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GEAR,
      CSR_KP,
      CSR_KI_DT,
      CSR_KD_OVER_DT,
      CSR_FF_GAIN,
      CSR_I_CLAMP,
      CSR_MIN_DUTY,
      CSR_STALL_TICKS
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAS,
      ST_TGT,
      ST_TGT_RND,
      ST_FF,
      ST_P,
      ST_I,
      ST_D,
      ST_SUM,
      ST_CLAMP,
      ST_FIN
   } msp_state_type;

endpackage

`default_nettype wire

// File: rtl/msp_if.sv
// Channel interfaces of the motor speed controller: request, response and
// register write port. Depends on msp_pkg.
`default_nettype none

interface msp_req_if import msp_pkg::*; #(parameter int COUNT_BITS = 12);
   logic                        valid;
   logic                        ready;
   logic signed [COUNT_BITS-1:0] encoder_count;
   logic signed [TARGET_W-1:0]   target_output_rpm;
   logic                        target_written;

   modport source (output valid, encoder_count, target_output_rpm, target_written,
                   input ready);
   modport sink   (input valid, encoder_count, target_output_rpm, target_written,
                   output ready);
endinterface

interface msp_rsp_if import msp_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       duty_forward;
   logic [DUTY_W-1:0]       duty_reverse;
   logic                    drive_on;
   logic                    stall_trip;
   logic signed [RPM_W-1:0] measured_motor_rpm;

   modport source (output valid, duty_forward, duty_reverse, drive_on, stall_trip,
                   measured_motor_rpm, input ready);
   modport sink   (input valid, duty_forward, duty_reverse, drive_on, stall_trip,
                   measured_motor_rpm, output ready);
endinterface

interface msp_csr_if import msp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/motor_speed_pi_ff_stall_unit.sv
// Motor speed controller top level: feedforward plus PID on one shared
// multiplier, duty mapping and stall trip. Depends on msp_pkg and msp_if.
//
// Use: one request per control tick on req_chan (encoder count delta and an
// optional new output-shaft target). Each request yields one response on
// rsp_chan with the two bridge duties, drive state, stall trip flag and the
// measured motor speed. Gains and limits are written on csr_chan, which is
// always ready; write only while no request is in flight.
// Sequencing: a taken request steps through measure, target, target rounding,
// feedforward, P, I, D, sum, clamp and final steps; the next request is taken
// only back in idle. The single 29x17 multiplier forms six products in turn
// under the sequencer, with the rounding, clamp and duty steps around it.
// Reset (synchronous, active high): registers return to their defaults, the
// drive enable is off, target, integrator, previous error and stall count are zero.
// Receiver stall: the response register holds its value; one more request
// may be taken and is worked up to its final step, where it waits for the
// response register to free up.
`default_nettype none

module motor_speed_pi_ff_stall_unit import msp_pkg::*; #(
   parameter int COUNT_BITS = 12,
   parameter int DUTY_MAX   = 1023
) (
   input  wire logic clock,
   input  wire logic reset,
   msp_req_if.sink   req_chan,
   msp_rsp_if.source rsp_chan,
   msp_csr_if.sink   csr_chan
);

   localparam int MEAS_W  = COUNT_BITS + 15;
   localparam int ERR_W   = ((MEAS_W > TGT_W) ? MEAS_W : TGT_W) + 1;
   localparam int DERR_W  = ERR_W + 1;
   localparam int MA_W    = DERR_W;
   localparam int MB_W    = GAIN_W + 1;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int RND_W   = PROD_W - 16;
   localparam int ISUM_W  = RND_W + 1;
   localparam int SUM_W   = RND_W + 2;
   localparam int OMAX    = DUTY_MAX * 256;
   localparam int OM_W    = $clog2(OMAX + 1);
   localparam int O_W     = OM_W + 1;
   localparam int FLOOR_W = DUTY_W + 8;
   localparam int MAG_W   = (OM_W > FLOOR_W) ? OM_W : FLOOR_W;
   localparam int M5_W    = OM_W + 3;

   localparam logic signed [SUM_W-1:0]  OMAX_S    = SUM_W'(OMAX);
   localparam logic [MAG_W-1:0]         OMAX_M    = MAG_W'(OMAX);
   localparam logic [M5_W-1:0]          OMAX_5    = M5_W'(OMAX);
   localparam logic signed [MEAS_W-1:0] NEAR_ZERO = MEAS_W'(256);
   localparam logic signed [PROD_W-1:0] HALF_Q16  = PROD_W'(32768);
   localparam logic signed [PROD_W-1:0] HALF_Q8   = PROD_W'(128);

   // registers
   logic [GEAR_W-1:0]  gear_ff;
   logic [GAIN_W-1:0]  kp_ff, ki_ff, kd_ff, ffg_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [DUTY_W-1:0]  min_duty_ff;
   logic [STALL_W-1:0] stall_ticks_ff;

   msp_state_type state_ff, state_in;

   logic signed [TARGET_W-1:0]   held_ff, held_in;
   logic                        en_ff, en_in;
   logic signed [INTEG_W-1:0]   integrator_ff, integrator_in;
   logic signed [ERR_W-1:0]     prev_ff, prev_in;
   logic [STALL_W-1:0]          stall_ff, stall_in;

   logic signed [COUNT_BITS-1:0] count_ff, count_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [MEAS_W-1:0]     meas_ff, meas_in;
   logic signed [TGT_W-1:0]      tgt_ff, tgt_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [DERR_W-1:0]     derr_ff, derr_in;
   logic signed [RND_W-1:0]      ffv_ff, ffv_in;
   logic signed [RND_W-1:0]      p_ff, p_in;
   logic signed [INTEG_W-1:0]    integ_ff, integ_in;
   logic signed [SUM_W-1:0]      acc_ff, acc_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [O_W-1:0]        o_ff, o_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]       fwd_ff, fwd_in, rev_ff, rev_in;
   logic                    drive_on_ff, drive_on_in;
   logic                    trip_ff, trip_in;
   logic signed [RPM_W-1:0] rpm_ff, rpm_in;

   // combinational
   logic                     req_accept, fin_load;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_r16_full, prod_r8_full;
   logic signed [RND_W-1:0]  prod_r16;
   logic signed [ISUM_W-1:0] isum, isum_c, lim_pos;
   logic signed [O_W-1:0]    o_abs;
   logic [OM_W-1:0]          mag;
   logic [M5_W-1:0]          mag5;
   logic [MAG_W-1:0]         mag_f, floor_q8;
   logic [MAG_W:0]           duty_full;
   logic                     stall_cond, trip;
   logic [STALL_W-1:0]       stall_next;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.duty_forward       = fwd_ff;
   assign rsp_chan.duty_reverse       = rev_ff;
   assign rsp_chan.drive_on           = drive_on_ff;
   assign rsp_chan.stall_trip         = trip_ff;
   assign rsp_chan.measured_motor_rpm = rpm_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_accept = 1'b0;
      fin_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_accept = req_chan.valid;
            if (req_chan.valid) state_in = ST_MEAS;
         end
         ST_MEAS:    state_in = ST_TGT;
         ST_TGT:     state_in = ST_TGT_RND;
         ST_TGT_RND: state_in = ST_FF;
         ST_FF:      state_in = ST_P;
         ST_P:       state_in = ST_I;
         ST_I:       state_in = ST_D;
         ST_D:       state_in = ST_SUM;
         ST_SUM:     state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_FIN;
         ST_FIN: begin
            fin_load = !rsp_valid_ff || rsp_chan.ready;
            if (fin_load) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MEAS: begin
            mul_a = MA_W'(count_ff);
            mul_b = MB_W'(MEAS_GAIN);
         end
         ST_TGT: begin
            mul_a = MA_W'(held_ff);
            mul_b = signed'({1'b0, gear_ff});
         end
         ST_FF: begin
            mul_a = MA_W'(tgt_ff);
            mul_b = signed'({1'b0, ffg_ff});
         end
         ST_P: begin
            mul_a = MA_W'(err_ff);
            mul_b = signed'({1'b0, kp_ff});
         end
         ST_I: begin
            mul_a = MA_W'(err_ff);
            mul_b = signed'({1'b0, ki_ff});
         end
         ST_D: begin
            mul_a = MA_W'(derr_ff);
            mul_b = signed'({1'b0, kd_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in       = mul_a * mul_b;
   assign prod_r16_full = prod_ff + HALF_Q16;
   assign prod_r8_full  = prod_ff + HALF_Q8;
   assign prod_r16      = prod_r16_full[PROD_W-1:16];

   // integrator clamp
   assign lim_pos = signed'(ISUM_W'({1'b0, limit_ff}));
   assign isum    = ISUM_W'(integrator_ff) + ISUM_W'(prod_r16);
   always_comb begin
      priority if (isum > lim_pos) begin
         isum_c = lim_pos;
      end else if (isum < -lim_pos) begin
         isum_c = -lim_pos;
      end else begin
         isum_c = isum;
      end
   end

   // stall check and duty mapping
   assign o_abs      = (o_ff < 0) ? -o_ff : o_ff;
   assign mag        = o_abs[OM_W-1:0];
   assign mag5       = {1'b0, mag, 2'b00} + M5_W'(mag);
   assign stall_cond = (mag5 > OMAX_5) && (meas_ff > -NEAR_ZERO) && (meas_ff < NEAR_ZERO);
   assign stall_next = !stall_cond ? '0 : ((&stall_ff) ? stall_ff : stall_ff + 1'b1);
   assign trip       = stall_next > stall_ticks_ff;
   assign floor_q8   = MAG_W'({min_duty_ff, 8'h00});

   always_comb begin
      mag_f = MAG_W'(mag);
      if (mag_f >= MAG_W'(MIN_MAG) && mag_f < floor_q8) mag_f = floor_q8;
      if (mag_f > OMAX_M) mag_f = OMAX_M;
   end

   assign duty_full = ((MAG_W + 1)'(mag_f) + (MAG_W + 1)'(128)) >> 8;

   // datapath next values
   always_comb begin
      held_in       = held_ff;
      en_in         = en_ff;
      integrator_in = integrator_ff;
      prev_in       = prev_ff;
      stall_in      = stall_ff;
      count_in      = count_ff;
      meas_in       = meas_ff;
      tgt_in        = tgt_ff;
      err_in        = err_ff;
      derr_in       = derr_ff;
      ffv_in        = ffv_ff;
      p_in          = p_ff;
      integ_in      = integ_ff;
      acc_in        = acc_ff;
      sum_in        = sum_ff;
      o_in          = o_ff;
      fwd_in        = fwd_ff;
      rev_in        = rev_ff;
      drive_on_in   = drive_on_ff;
      trip_in       = trip_ff;
      rpm_in        = rpm_ff;
      rsp_valid_in  = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      if (req_accept) begin
         count_in = req_chan.encoder_count;
         if (req_chan.target_written) begin
            held_in = req_chan.target_output_rpm;
            en_in   = (req_chan.target_output_rpm != '0);
         end
      end

      unique case (state_ff)
         ST_TGT:     meas_in = prod_ff[MEAS_W-1:0];
         ST_TGT_RND: tgt_in = prod_r8_full[TGT_W+7:8];
         ST_FF:      err_in = ERR_W'(tgt_ff) - ERR_W'(meas_ff);
         ST_P: begin
            ffv_in  = prod_r16;
            derr_in = DERR_W'(err_ff) - DERR_W'(prev_ff);
         end
         ST_I:       p_in = prod_r16;
         ST_D: begin
            integ_in = isum_c[INTEG_W-1:0];
            acc_in   = SUM_W'(ffv_ff) + SUM_W'(p_ff);
         end
         ST_SUM:     sum_in = acc_ff + SUM_W'(integ_ff) + SUM_W'(prod_r16);
         ST_CLAMP: begin
            priority if (sum_ff > OMAX_S) begin
               o_in = O_W'(OMAX_S);
            end else if (sum_ff < -OMAX_S) begin
               o_in = O_W'(-OMAX_S);
            end else begin
               o_in = sum_ff[O_W-1:0];
            end
         end
         ST_FIN: begin
            if (fin_load) begin
               rsp_valid_in = 1'b1;
               rpm_in       = RPM_W'(meas_ff);
               fwd_in       = '0;
               rev_in       = '0;
               trip_in      = 1'b0;
               drive_on_in  = 1'b0;
               if (!en_ff) begin
                  integrator_in = '0;
                  prev_in       = '0;
                  stall_in      = '0;
               end else begin
                  integrator_in = integ_ff;
                  prev_in       = err_ff;
                  stall_in      = stall_next;
                  if (trip) begin
                     en_in         = 1'b0;
                     held_in       = '0;
                     integrator_in = '0;
                     trip_in       = 1'b1;
                  end else begin
                     drive_on_in = 1'b1;
                     if (o_ff >= 0) begin
                        fwd_in = duty_full[DUTY_W-1:0];
                     end else begin
                        rev_in = duty_full[DUTY_W-1:0];
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         en_ff         <= 1'b0;
         integrator_ff <= '0;
         prev_ff       <= '0;
         stall_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_ff       <= held_in;
         en_ff         <= en_in;
         integrator_ff <= integrator_in;
         prev_ff       <= prev_in;
         stall_ff      <= stall_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      prod_ff     <= prod_in;
      meas_ff     <= meas_in;
      tgt_ff      <= tgt_in;
      err_ff      <= err_in;
      derr_ff     <= derr_in;
      ffv_ff      <= ffv_in;
      p_ff        <= p_in;
      integ_ff    <= integ_in;
      acc_ff      <= acc_in;
      sum_ff      <= sum_in;
      o_ff        <= o_in;
      fwd_ff      <= fwd_in;
      rev_ff      <= rev_in;
      drive_on_ff <= drive_on_in;
      trip_ff     <= trip_in;
      rpm_ff      <= rpm_in;
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff        <= GEAR_RESET;
         kp_ff          <= KP_RESET;
         ki_ff          <= KI_RESET;
         kd_ff          <= KD_RESET;
         ffg_ff         <= FF_RESET;
         limit_ff       <= LIMIT_RESET;
         min_duty_ff    <= MIN_DUTY_RESET;
         stall_ticks_ff <= STALL_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_GEAR:        gear_ff        <= csr_chan.data[GEAR_W-1:0];
            CSR_KP:          kp_ff          <= csr_chan.data[GAIN_W-1:0];
            CSR_KI_DT:       ki_ff          <= csr_chan.data[GAIN_W-1:0];
            CSR_KD_OVER_DT:  kd_ff          <= csr_chan.data[GAIN_W-1:0];
            CSR_FF_GAIN:     ffg_ff         <= csr_chan.data[GAIN_W-1:0];
            CSR_I_CLAMP:     limit_ff       <= csr_chan.data[LIMIT_W-1:0];
            CSR_MIN_DUTY:    min_duty_ff    <= csr_chan.data[DUTY_W-1:0];
            CSR_STALL_TICKS: stall_ticks_ff <= csr_chan.data[STALL_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire
